// ===== sv/gbs_pkg.sv =====
`timescale 1ns / 1ps
package gbs_pkg;

    // Field widths of one box
    localparam int CoordW = 16;
    localparam int ScoreW = 16;
    localparam int ClassW = 7;
    localparam int BoxW   = 4 * CoordW;
    // Stored entry: box, then score, then class
    localparam int EntryW = BoxW + ScoreW + ClassW;
    localparam int DataW  = ((EntryW + 7) / 8) * 8;

    // Candidate store
    localparam int CandDepth = 1024;
    localparam int CandAw    = $clog2(CandDepth);
    localparam int CandCntW  = CandAw + 1;

    // Kept store
    localparam int KeepMax  = 64;
    localparam int KeepAw   = $clog2(KeepMax);
    localparam int KeepCntW = KeepAw + 1;

    // IoU arithmetic widths
    localparam int AreaW = 2 * CoordW;
    localparam int UniW  = AreaW + 1;
    localparam int ProdW = ScoreW + UniW;

    // Configuration registers
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] REG_IOU_THR  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_KEPT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_IGN_CLS  = 2'd2;

    localparam logic [ScoreW-1:0] IouThrReset  = 16'd29491;
    localparam logic [ClassW-1:0] MaxKeptReset = 7'd64;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_START,
        S_SCAN,
        S_SELECT,
        S_LATCH,
        S_CMP_RD,
        S_CMP_P1,
        S_CMP_P2,
        S_CMP_P3,
        S_CMP_P4,
        S_CMP_DEC,
        S_KEEP,
        S_NEXT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic scan_clr;
        logic scan_run;
        logic fetch;
        logic latch;
        logic k_clr;
        logic k_inc;
        logic keep;
        logic out_load;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic                final_load;
        logic                scan_done;
        logic                best_vld;
        logic                cmp_end;
        logic                suppress;
        logic                keep_full;
        logic                out_taken;
        logic                emit_end;
        logic [KeepCntW-1:0] kept_cnt;
    } t_stat;

endpackage

// ===== sv/greedy_box_suppression.sv =====
`timescale 1ns / 1ps
// Greedy non-maximum suppression over up to 1024 boxes per set. Boxes are
// taken at one item per cycle until the item with tlast; boxes beyond 1024
// are dropped and tuser is raised on every result of that set. Suppression
// then picks candidates in descending score order (ties in arrival order)
// by scanning the whole candidate store once per pick, and checks each pick
// against the boxes kept so far through one shared IoU pipeline. Kept boxes
// (at most max_kept, capped at 64) are then sent out one at a time, each
// only after the previous one is taken, the last marked with tlast. The
// single read port of the candidate store sets the scan length. Input is
// accepted only while no set is in progress.
module greedy_box_suppression (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tdata: left, top, right, bottom, score, class, one zero pad bit
    input  logic [gbs_pkg::DataW-1:0]    s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic                         s_axis_tlast,
    // tdata: kept_left, kept_top, kept_right, kept_bottom, kept_score,
    // kept_class, one zero pad bit
    output logic [gbs_pkg::DataW-1:0]    m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic                         m_axis_tlast,
    // tuser: overflowed
    output logic                         m_axis_tuser,
    input  logic                         i_cfg_we,
    input  logic [gbs_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [gbs_pkg::CfgDataW-1:0] i_cfg_data
);

    gbs_pkg::t_cmd  w_cmd;
    gbs_pkg::t_stat w_stat;

    gbs_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    gbs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_valid (s_axis_tvalid),
        .i_in_data  (s_axis_tdata),
        .i_in_last  (s_axis_tlast),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast),
        .o_out_ovf  (m_axis_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    assign s_axis_tready = w_cmd.in_ready;

`ifndef ASSERT_OFF
    // A result is only ever shown once at least one box has been kept.
    a_out_has_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_stat.kept_cnt != '0))
        else $error("result shown with no kept box");

    // No new box is taken while a result is still waiting.
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input open while result pending");

    // The kept count never passes the store size.
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.kept_cnt <= gbs_pkg::KeepCntW'(gbs_pkg::KeepMax))
        else $error("kept count beyond store");
`endif

endmodule

// ===== sv/gbs_ram.sv =====
`timescale 1ns / 1ps
module gbs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gbs_ctrl.sv =====
`timescale 1ns / 1ps
module gbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gbs_pkg::t_stat i_stat,
    output gbs_pkg::t_cmd  o_cmd
);

    gbs_pkg::t_state r_state;
    gbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbs_pkg::S_IDLE: begin
                if (i_stat.final_load) n_state = gbs_pkg::S_SCAN_START;
            end
            gbs_pkg::S_SCAN_START: n_state = gbs_pkg::S_SCAN;
            gbs_pkg::S_SCAN: begin
                if (i_stat.scan_done) n_state = gbs_pkg::S_SELECT;
            end
            gbs_pkg::S_SELECT: begin
                n_state = i_stat.best_vld ? gbs_pkg::S_LATCH : gbs_pkg::S_EMIT_RD;
            end
            gbs_pkg::S_LATCH: n_state = gbs_pkg::S_CMP_RD;
            gbs_pkg::S_CMP_RD: begin
                n_state = i_stat.cmp_end ? gbs_pkg::S_KEEP : gbs_pkg::S_CMP_P1;
            end
            gbs_pkg::S_CMP_P1: n_state = gbs_pkg::S_CMP_P2;
            gbs_pkg::S_CMP_P2: n_state = gbs_pkg::S_CMP_P3;
            gbs_pkg::S_CMP_P3: n_state = gbs_pkg::S_CMP_P4;
            gbs_pkg::S_CMP_P4: n_state = gbs_pkg::S_CMP_DEC;
            gbs_pkg::S_CMP_DEC: begin
                n_state = i_stat.suppress ? gbs_pkg::S_SCAN_START : gbs_pkg::S_CMP_RD;
            end
            gbs_pkg::S_KEEP: n_state = gbs_pkg::S_NEXT;
            gbs_pkg::S_NEXT: begin
                n_state = i_stat.keep_full ? gbs_pkg::S_EMIT_RD : gbs_pkg::S_SCAN_START;
            end
            gbs_pkg::S_EMIT_RD: n_state = gbs_pkg::S_EMIT_LD;
            gbs_pkg::S_EMIT_LD: n_state = gbs_pkg::S_EMIT_WAIT;
            gbs_pkg::S_EMIT_WAIT: begin
                if (i_stat.out_taken) begin
                    n_state = i_stat.emit_end ? gbs_pkg::S_DONE : gbs_pkg::S_EMIT_RD;
                end
            end
            gbs_pkg::S_DONE: n_state = gbs_pkg::S_IDLE;
            default: n_state = gbs_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            gbs_pkg::S_IDLE:       o_cmd.in_ready = 1'b1;
            gbs_pkg::S_SCAN_START: o_cmd.scan_clr = 1'b1;
            gbs_pkg::S_SCAN:       o_cmd.scan_run = 1'b1;
            gbs_pkg::S_SELECT: begin
                o_cmd.fetch = 1'b1;
                o_cmd.k_clr = 1'b1;
            end
            gbs_pkg::S_LATCH:      o_cmd.latch = 1'b1;
            gbs_pkg::S_CMP_DEC:    o_cmd.k_inc = !i_stat.suppress;
            gbs_pkg::S_KEEP:       o_cmd.keep = 1'b1;
            gbs_pkg::S_NEXT:       o_cmd.k_clr = 1'b1;
            gbs_pkg::S_EMIT_LD:    o_cmd.out_load = 1'b1;
            gbs_pkg::S_DONE:       o_cmd.done = 1'b1;
            default:               o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/gbs_dp.sv =====
`timescale 1ns / 1ps
module gbs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbs_pkg::t_cmd                 i_cmd,
    output gbs_pkg::t_stat                o_stat,
    input  logic                          i_in_valid,
    input  logic [gbs_pkg::DataW-1:0]     i_in_data,
    input  logic                          i_in_last,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [gbs_pkg::DataW-1:0]     o_out_data,
    output logic                          o_out_last,
    output logic                          o_out_ovf,
    input  logic                          i_cfg_we,
    input  logic [gbs_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [gbs_pkg::CfgDataW-1:0]  i_cfg_data
);

    localparam int CW = gbs_pkg::CoordW;
    localparam int SW = gbs_pkg::ScoreW;
    localparam int KW = gbs_pkg::ClassW;
    localparam int BW = gbs_pkg::BoxW;
    localparam int EW = gbs_pkg::EntryW;

    // Configuration registers
    logic [SW-1:0] r_thr;
    logic [KW-1:0] r_maxk;
    logic          r_ign;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= gbs_pkg::IouThrReset;
            r_maxk <= gbs_pkg::MaxKeptReset;
            r_ign  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gbs_pkg::REG_IOU_THR:  r_thr  <= i_cfg_data[SW-1:0];
                gbs_pkg::REG_MAX_KEPT: r_maxk <= i_cfg_data[KW-1:0];
                gbs_pkg::REG_IGN_CLS:  r_ign  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective keep limit: zero counts as one, saturated at the store size.
    logic [gbs_pkg::KeepCntW-1:0] w_limit;
    always_comb begin
        if (r_maxk == '0) begin
            w_limit = gbs_pkg::KeepCntW'(1);
        end else if (r_maxk > KW'(gbs_pkg::KeepMax)) begin
            w_limit = gbs_pkg::KeepCntW'(gbs_pkg::KeepMax);
        end else begin
            w_limit = r_maxk[gbs_pkg::KeepCntW-1:0];
        end
    end

    // Loading: count, overflow flag.
    logic                         w_load;
    logic                         w_room;
    logic [gbs_pkg::CandCntW-1:0] r_cnt;
    logic                         r_ovf;

    assign w_load = i_cmd.in_ready && i_in_valid;
    assign w_room = !r_cnt[gbs_pkg::CandCntW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.done) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_load) begin
            if (w_room) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Candidate store.
    logic [gbs_pkg::CandAw-1:0] w_idx_a;
    logic [gbs_pkg::CandAw-1:0] w_cand_raddr;
    logic [gbs_pkg::DataW-1:0]  w_cand_rdata;
    logic [gbs_pkg::CandCntW-1:0] r_idx;
    logic [gbs_pkg::CandAw-1:0] r_best_idx;

    assign w_idx_a      = r_idx[gbs_pkg::CandAw-1:0];
    assign w_cand_raddr = i_cmd.fetch ? r_best_idx : w_idx_a;

    gbs_ram #(
        .Width(gbs_pkg::DataW),
        .Depth(gbs_pkg::CandDepth)
    ) u_cand_ram (
        .i_clk  (i_clk),
        .i_we   (w_load && w_room),
        .i_waddr(r_cnt[gbs_pkg::CandAw-1:0]),
        .i_wdata(i_in_data),
        .i_raddr(w_cand_raddr),
        .o_rdata(w_cand_rdata)
    );

    // Score scan: finds the best candidate ranked after the previous pick.
    logic                       r_sv;
    logic [gbs_pkg::CandAw-1:0] r_sidx;
    logic                       r_have_prev;
    logic [SW-1:0]              r_prev_score;
    logic [gbs_pkg::CandAw-1:0] r_prev_idx;
    logic                       r_best_vld;
    logic [SW-1:0]              r_best_score;
    logic [SW-1:0]              w_sscore;
    logic                       w_elig;
    logic                       w_better;

    assign w_sscore = w_cand_rdata[BW +: SW];
    assign w_elig   = !r_have_prev || (w_sscore < r_prev_score) ||
                      ((w_sscore == r_prev_score) && (r_sidx > r_prev_idx));
    assign w_better = !r_best_vld || (w_sscore > r_best_score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv        <= 1'b0;
            r_have_prev <= 1'b0;
            r_best_vld  <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_sv <= 1'b0;
            if (w_load && i_in_last) begin
                r_have_prev <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_idx      <= '0;
                r_best_vld <= 1'b0;
            end
            if (i_cmd.scan_run && (r_idx < r_cnt)) begin
                r_idx  <= r_idx + 1'b1;
                r_sv   <= 1'b1;
                r_sidx <= w_idx_a;
            end
            if (r_sv && w_elig && w_better) begin
                r_best_vld   <= 1'b1;
                r_best_score <= w_sscore;
                r_best_idx   <= r_sidx;
            end
            if (i_cmd.fetch) begin
                r_have_prev  <= 1'b1;
                r_prev_score <= r_best_score;
                r_prev_idx   <= r_best_idx;
            end
        end
    end

    // Current candidate.
    logic [EW-1:0]             r_cand;
    logic [gbs_pkg::AreaW-1:0] r_carea;
    logic [CW-1:0]             w_cw;
    logic [CW-1:0]             w_ch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cand <= w_cand_rdata[EW-1:0];
        end
    end

    always_comb begin
        w_cw = (r_cand[2*CW +: CW] > r_cand[0 +: CW]) ?
               r_cand[2*CW +: CW] - r_cand[0 +: CW] : '0;
        w_ch = (r_cand[3*CW +: CW] > r_cand[CW +: CW]) ?
               r_cand[3*CW +: CW] - r_cand[CW +: CW] : '0;
    end

    always_ff @(posedge i_clk) begin
        r_carea <= w_cw * w_ch;
    end

    // Kept store and its counters.
    logic [gbs_pkg::KeepCntW-1:0] r_kc;
    logic [gbs_pkg::KeepCntW-1:0] r_k;
    logic [gbs_pkg::DataW-1:0]    w_kept_rdata;
    logic [gbs_pkg::DataW-1:0]    w_kept_wdata;

    assign w_kept_wdata = gbs_pkg::DataW'(r_cand);

    gbs_ram #(
        .Width(gbs_pkg::DataW),
        .Depth(gbs_pkg::KeepMax)
    ) u_kept_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.keep),
        .i_waddr(r_kc[gbs_pkg::KeepAw-1:0]),
        .i_wdata(w_kept_wdata),
        .i_raddr(r_k[gbs_pkg::KeepAw-1:0]),
        .o_rdata(w_kept_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kc <= '0;
            r_k  <= '0;
        end else begin
            if (w_load && i_in_last) begin
                r_kc <= '0;
            end else if (i_cmd.keep) begin
                r_kc <= r_kc + 1'b1;
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc || i_cmd.out_load) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // IoU pipeline stage 1: overlap spans, kept box spans, class match.
    logic [CW-1:0] w_ilo_x, w_ihi_x, w_ilo_y, w_ihi_y;
    logic [CW-1:0] r_iw, r_ih, r_kw, r_kh;
    logic          r_m1, r_m2, r_m3, r_m4;

    always_comb begin
        w_ilo_x = (r_cand[0 +: CW] > w_kept_rdata[0 +: CW]) ?
                  r_cand[0 +: CW] : w_kept_rdata[0 +: CW];
        w_ihi_x = (r_cand[2*CW +: CW] < w_kept_rdata[2*CW +: CW]) ?
                  r_cand[2*CW +: CW] : w_kept_rdata[2*CW +: CW];
        w_ilo_y = (r_cand[CW +: CW] > w_kept_rdata[CW +: CW]) ?
                  r_cand[CW +: CW] : w_kept_rdata[CW +: CW];
        w_ihi_y = (r_cand[3*CW +: CW] < w_kept_rdata[3*CW +: CW]) ?
                  r_cand[3*CW +: CW] : w_kept_rdata[3*CW +: CW];
    end

    always_ff @(posedge i_clk) begin
        r_iw <= (w_ihi_x > w_ilo_x) ? w_ihi_x - w_ilo_x : '0;
        r_ih <= (w_ihi_y > w_ilo_y) ? w_ihi_y - w_ilo_y : '0;
        r_kw <= (w_kept_rdata[2*CW +: CW] > w_kept_rdata[0 +: CW]) ?
                w_kept_rdata[2*CW +: CW] - w_kept_rdata[0 +: CW] : '0;
        r_kh <= (w_kept_rdata[3*CW +: CW] > w_kept_rdata[CW +: CW]) ?
                w_kept_rdata[3*CW +: CW] - w_kept_rdata[CW +: CW] : '0;
        r_m1 <= r_ign || (w_kept_rdata[BW+SW +: KW] == r_cand[BW+SW +: KW]);
    end

    // Stage 2: intersection and kept area.
    logic [gbs_pkg::AreaW-1:0] r_inter2, r_karea, r_inter3, r_inter4;
    logic [gbs_pkg::UniW-1:0]  r_uni;
    logic [gbs_pkg::ProdW-1:0] r_prod;
    logic                      r_unz;

    always_ff @(posedge i_clk) begin
        r_inter2 <= r_iw * r_ih;
        r_karea  <= r_kw * r_kh;
        r_m2     <= r_m1;
        // Stage 3: union.
        r_uni    <= gbs_pkg::UniW'(r_carea) + gbs_pkg::UniW'(r_karea)
                    - gbs_pkg::UniW'(r_inter2);
        r_inter3 <= r_inter2;
        r_m3     <= r_m2;
        // Stage 4: threshold times union.
        r_prod   <= r_thr * r_uni;
        r_inter4 <= r_inter3;
        r_unz    <= (r_uni != '0);
        r_m4     <= r_m3;
    end

    // Output register.
    logic                       r_ovalid;
    logic [gbs_pkg::DataW-1:0]  r_odata;
    logic                       r_olast;
    logic                       r_oovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= gbs_pkg::DataW'(w_kept_rdata[EW-1:0]);
            r_olast <= (r_k + 1'b1 == r_kc);
            r_oovf  <= r_ovf;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;
    assign o_out_ovf   = r_oovf;

    // Status to the controller.
    always_comb begin
        o_stat.final_load = w_load && i_in_last;
        o_stat.scan_done  = (r_idx == r_cnt) && !r_sv;
        o_stat.best_vld   = r_best_vld;
        o_stat.cmp_end    = (r_k == r_kc);
        o_stat.suppress   = r_m4 && r_unz &&
                            ({1'b0, r_inter4, 16'h0} > r_prod);
        o_stat.keep_full  = (r_kc >= w_limit);
        o_stat.out_taken  = r_ovalid && i_out_ready;
        o_stat.emit_end   = (r_k == r_kc);
        o_stat.kept_cnt   = r_kc;
    end

endmodule

// ===== test/box_checker.sv =====
`timescale 1ns / 1ps
// Watches both item channels and the register port, predicts the kept boxes
// of every set and compares each result item against the oldest prediction.
module box_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [gbs_pkg::DataW-1:0]    i_in_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_in_last,
    input  logic [gbs_pkg::DataW-1:0]    i_out_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_out_last,
    input  logic                         i_out_user,
    input  logic                         i_cfg_we,
    input  logic [gbs_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [gbs_pkg::CfgDataW-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import gbs_pkg::*;

    typedef struct packed {
        logic [CoordW-1:0] l, t, r, b;
        logic [ScoreW-1:0] score;
        logic [ClassW-1:0] cls;
    } box_t;

    typedef struct {
        box_t bx;
        logic last;
        logic ovf;
    } kept_item_t;

    box_t        cand_boxes[$];
    logic        cand_dropped;
    kept_item_t  kept_expected[$];
    logic [15:0] thr;
    logic [6:0]  keep_limit_reg;
    logic        any_class;

    function automatic box_t unpack_box(logic [DataW-1:0] d);
        box_t bx;
        bx.l     = d[15:0];
        bx.t     = d[31:16];
        bx.r     = d[47:32];
        bx.b     = d[63:48];
        bx.score = d[79:64];
        bx.cls   = d[86:80];
        return bx;
    endfunction

    function automatic longint unsigned seg(longint unsigned lo, longint unsigned hi);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // Intersection over union above the threshold, in exact integer form.
    function automatic bit overlaps_too_much(box_t a, box_t c);
        longint unsigned inter, uni, area_a, area_c;
        inter  = seg((a.l > c.l) ? a.l : c.l, (a.r < c.r) ? a.r : c.r) *
                 seg((a.t > c.t) ? a.t : c.t, (a.b < c.b) ? a.b : c.b);
        area_a = seg(a.l, a.r) * seg(a.t, a.b);
        area_c = seg(c.l, c.r) * seg(c.t, c.b);
        uni    = area_a + area_c - inter;
        if (uni == 0) return 1'b0;
        return (inter << 16) > (longint'(thr) * uni);
    endfunction

    // Greedy suppression over the stored set; adds one prediction per kept box.
    task automatic suppress_set();
        int   order[$];
        box_t kept[$];
        int   j, limit;
        bit   keep;
        kept_item_t ki;
        for (int i = 0; i < cand_boxes.size(); i++) begin
            j = order.size();
            while (j > 0 && cand_boxes[order[j-1]].score < cand_boxes[i].score) j--;
            order.insert(j, i);
        end
        limit = keep_limit_reg;
        if (limit < 1) limit = 1;
        if (limit > KeepMax) limit = KeepMax;
        for (int i = 0; i < order.size() && kept.size() < limit; i++) begin
            keep = 1'b1;
            foreach (kept[k]) begin
                if (!any_class && kept[k].cls != cand_boxes[order[i]].cls) continue;
                if (overlaps_too_much(cand_boxes[order[i]], kept[k])) begin
                    keep = 1'b0;
                    break;
                end
            end
            if (keep) begin
                kept.insert(kept.size(), cand_boxes[order[i]]);
                ki.bx   = cand_boxes[order[i]];
                ki.last = 1'b0;
                ki.ovf  = cand_dropped;
                kept_expected.insert(kept_expected.size(), ki);
            end
        end
        kept_expected[kept_expected.size()-1].last = 1'b1;
        cand_boxes.delete();
        cand_dropped = 1'b0;
    endtask

    // Compares one result item with the oldest prediction.
    task automatic check_result();
        box_t       got;
        kept_item_t want;
        got = unpack_box(i_out_data);
        if (kept_expected.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("unexpected result: l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d",
                         got.l, got.t, got.r, got.b, got.score, got.cls);
            return;
        end
        want = kept_expected.pop_front();
        if (got != want.bx || i_out_last !== want.last || i_out_user !== want.ovf ||
            i_out_data[DataW-1] !== 1'b0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("mismatch: expected l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d %s%0d %s%0d",
                         want.bx.l, want.bx.t, want.bx.r, want.bx.b, want.bx.score,
                         want.bx.cls, "last=", want.last, "ovf=", want.ovf);
                $display("          actual   l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d %s%0d %s%0d",
                         got.l, got.t, got.r, got.b, got.score, got.cls,
                         "last=", i_out_last, "ovf=", i_out_user);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_boxes.delete();
            kept_expected.delete();
            cand_dropped   = 1'b0;
            thr            = IouThrReset;
            keep_limit_reg = MaxKeptReset;
            any_class      = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IOU_THR:  thr = i_cfg_data;
                    REG_MAX_KEPT: keep_limit_reg = i_cfg_data[6:0];
                    REG_IGN_CLS:  any_class = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                if (cand_boxes.size() < CandDepth)
                    cand_boxes.insert(cand_boxes.size(), unpack_box(i_in_data));
                else
                    cand_dropped = 1'b1;
                if (i_in_last) suppress_set();
            end
        end
        o_pending = kept_expected.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Drives sets of boxes into the suppression block under several register
// settings, with random idling on both sides, and gives the verdict.
module testbench;
    import gbs_pkg::*;

    localparam int HangLimit = 100000;

    logic                i_clk;
    logic                i_rst_n;
    logic [DataW-1:0]    s_axis_tdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic                s_axis_tlast;
    logic [DataW-1:0]    m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                m_axis_tlast;
    logic                m_axis_tuser;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    int                  fail_count;
    int                  pending;
    int                  quiet_cycles;
    bit                  no_idle;
    bit                  hold_req;
    bit                  hold_done;
    int                  cx, cy;

    greedy_box_suppression uut (.*);

    box_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_last   (s_axis_tlast),
        .i_out_data  (m_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_last  (m_axis_tlast),
        .i_out_user  (m_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or one long hold-off when asked.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 12);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HangLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_box(input logic [15:0] l, t, r, b, s, input logic [6:0] c,
                            input logic last);
        if (!no_idle && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tdata  <= {1'b0, c, s, b, r, t, l};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Sender pause until every predicted result has come, then a short drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random box near the current cluster centre, now and then wild values.
    task automatic random_box(input logic last);
        logic [15:0] l, t, w, h, s;
        logic [6:0]  c;
        l = 16'(cx + $urandom_range(0, 600));
        t = 16'(cy + $urandom_range(0, 600));
        w = 16'($urandom_range(1, 1500));
        h = 16'($urandom_range(1, 1500));
        s = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 7) << 13) : 16'($urandom);
        c = ($urandom_range(15) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2));
        if ($urandom_range(15) == 0)
            send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), s, c,
                     last);
        else
            send_box(l, t, l + w, t + h, s, c, last);
    endtask

    task automatic random_set(input int n);
        cx = $urandom_range(0, 30000);
        cy = $urandom_range(0, 30000);
        for (int i = 0; i < n; i++) random_box(i == n - 1);
    endtask

    task automatic directed_set();
        send_box(100, 100, 500, 500, 40000, 3, 1'b0);
        send_box(100, 100, 500, 500, 40000, 3, 1'b0);   // duplicate, equal score
        send_box(100, 100, 500, 500, 30000, 4, 1'b0);   // same place, other class
        send_box(120, 110, 520, 510, 50000, 3, 1'b0);
        send_box(600, 600, 600, 900, 20000, 3, 1'b0);   // zero width
        send_box(700, 700, 700, 700, 0, 3, 1'b0);       // zero area, zero union
        send_box(900, 900, 800, 800, 0, 3, 1'b1);       // inverted edges
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_IOU_THR;
        i_cfg_data    <= '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, special cases, register extremes.
        send_box(0, 0, 32768, 32768, 65535, 79, 1'b1);
        wait_idle();
        directed_set();
        wait_idle();
        write_reg(REG_IGN_CLS, 1);
        directed_set();
        wait_idle();
        write_reg(REG_IOU_THR, 0);
        write_reg(REG_MAX_KEPT, 0);
        directed_set();
        wait_idle();
        write_reg(REG_IOU_THR, 16'hFFFF);
        write_reg(REG_MAX_KEPT, 127);
        write_reg(REG_IGN_CLS, 0);
        directed_set();
        wait_idle();

        // Random phases under random settings.
        for (int p = 0; p < 12; p++) begin
            write_reg(REG_IOU_THR, (p % 4 == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom));
            write_reg(REG_MAX_KEPT,
                      (p % 3 == 0) ? 16'($urandom_range(1, 3)) : 16'($urandom_range(0, 127)));
            write_reg(REG_IGN_CLS, 16'($urandom_range(1)));
            no_idle = (p == 5);
            if (p == 7) hold_req = 1'b1;
            for (int s = 0; s < 5; s++) random_set($urandom_range(1, 10));
            wait_idle();
        end
        no_idle = 1'b0;

        // Many disjoint boxes so that the keep limit of 64 is reached.
        write_reg(REG_IOU_THR, 29491);
        write_reg(REG_MAX_KEPT, 64);
        for (int i = 0; i < 70; i++)
            send_box(16'(i * 400), 0, 16'(i * 400 + 300), 300, 16'($urandom), 1, i == 69);
        wait_idle();

        // Overfill the candidate store; then a normal set must come out clean.
        write_reg(REG_MAX_KEPT, 1);
        cx = 1000;
        cy = 1000;
        for (int i = 0; i < CandDepth + 2; i++) random_box(i == CandDepth + 1);
        wait_idle();
        random_set(4);
        wait_idle();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gbs_pkg.sv
sv/gbs_ram.sv
sv/gbs_ctrl.sv
sv/gbs_dp.sv
sv/greedy_box_suppression.sv
test/box_checker.sv
test/testbench.sv
